// ===== hw/rtl/pcic_pkg.sv =====
// Package: shared widths, operation codes, controller states and command types.
`default_nettype none

package pcic_pkg;

  // Default sizing, taken up by the top level and the datapath
  localparam int unsigned CELL_COUNT_DEF = 4096;
  localparam int unsigned INDEX_BITS_DEF = 48;

  // Port field widths
  localparam int unsigned PointW   = 48;
  localparam int unsigned CellW    = 12;
  localparam int unsigned ThrW     = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned SDataW   = 64;
  localparam int unsigned SUserW   = 1;
  localparam int unsigned MDataW   = 232;
  localparam int unsigned MDataPad = 3;

  // Result beat bit positions used outside the datapath
  localparam int unsigned MBitIvalid = 3;
  localparam int unsigned MBitOerr   = 228;

  // Operation codes carried on s_axis_tuser
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_UPDATE
  } pcic_state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;
    logic rd_en;
    logic calc_en;
    logic upd_en;
  } pcic_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
  } pcic_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pcic_ctrl.sv =====
// Controller: sequences the clearing sweep and the read, calculate, update steps per beat.
`default_nettype none

module pcic_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  input  wire pcic_pkg::pcic_stat_t stat_i,
  output pcic_pkg::pcic_cmd_t       cmd_o
);
  import pcic_pkg::*;

  pcic_state_e state_q, state_d;
  logic        m_valid_q, m_valid_d;
  logic        out_free;

  assign out_free = !m_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_CALC;
      end
      ST_CALC: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.rd_en   = s_axis_tvalid;
      end
      ST_CALC: begin
        cmd_o.calc_en = 1'b1;
      end
      ST_UPDATE: begin
        cmd_o.upd_en = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Hold the result beat until the sink takes it
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.upd_en) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pcic_dp.sv =====
// Datapath: cell store, gap arithmetic, saturating counters and the result register.
`default_nettype none

module pcic_dp #(
  parameter int unsigned CELL_COUNT = pcic_pkg::CELL_COUNT_DEF,
  parameter int unsigned INDEX_BITS = pcic_pkg::INDEX_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [pcic_pkg::ThrW-1:0]     cfg_wdata_i,
  input  wire logic [pcic_pkg::SDataW-1:0]   s_tdata_i,
  input  wire logic [pcic_pkg::SUserW-1:0]   s_tuser_i,
  input  wire pcic_pkg::pcic_cmd_t           cmd_i,
  output pcic_pkg::pcic_stat_t               stat_o,
  output logic [pcic_pkg::MDataW-1:0]        m_tdata_o
);
  import pcic_pkg::*;

  localparam int unsigned AddrW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned CntW  = $clog2(CELL_COUNT + 1);
  localparam int unsigned IW    = INDEX_BITS;
  localparam int unsigned RowW  = 4 * IW;

  // Widen or trim a stored value onto a 48-bit port field
  function automatic logic [PointW-1:0] to_port(logic [IW-1:0] v);
    logic [IW+PointW-1:0] e;
    e = {{PointW{1'b0}}, v};
    return e[PointW-1:0];
  endfunction

  // Configuration
  logic [ThrW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Unpack the incoming beat
  logic [IW+PointW-1:0]     pidx_ext;
  logic [IW-1:0]            pidx_in;
  logic [CellW-1:0]         cell_in;
  logic [AddrW+CellW-1:0]   cell_ext;
  logic [AddrW-1:0]         addr_in;
  logic [CntW+CellW-1:0]    cell_cmp;
  logic [CntW+CellW-1:0]    count_cmp;
  logic                     in_range;

  assign pidx_ext  = {{IW{1'b0}}, s_tdata_i[PointW-1:0]};
  assign pidx_in   = pidx_ext[IW-1:0];
  assign cell_in   = s_tdata_i[PointW+CellW-1:PointW];
  assign cell_ext  = {{AddrW{1'b0}}, cell_in};
  assign addr_in   = cell_ext[AddrW-1:0];
  assign cell_cmp  = {{CntW{1'b0}}, cell_in};
  assign count_cmp = {{CellW{1'b0}}, CntW'(CELL_COUNT)};
  assign in_range  = cell_cmp < count_cmp;

  logic             op_q;
  logic [IW-1:0]    pidx_q;
  logic [AddrW-1:0] addr_q;
  logic             in_range_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      op_q       <= s_tuser_i[0];
      pidx_q     <= pidx_in;
      addr_q     <= addr_in;
      in_range_q <= in_range;
    end
  end

  // Clearing sweep over the valid store after reset
  logic [AddrW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign stat_o.clr_last = (clr_cnt_q == AddrW'(CELL_COUNT - 1));

  // Cell stores: valid bits and rows of {covered, points, end, start}
  logic            vld_mem [CELL_COUNT];
  logic [RowW-1:0] row_mem [CELL_COUNT];
  logic            vld_rd_q;
  logic [RowW-1:0] row_rd_q;
  logic            row_we;
  logic [RowW-1:0] row_wd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      vld_mem[clr_cnt_q] <= 1'b0;
    end else if (cmd_i.upd_en && row_we) begin
      vld_mem[addr_q] <= 1'b1;
    end
    if (cmd_i.rd_en) begin
      vld_rd_q <= vld_mem[addr_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_en && row_we) begin
      row_mem[addr_q] <= row_wd;
    end
    if (cmd_i.rd_en) begin
      row_rd_q <= row_mem[addr_in];
    end
  end

  logic [IW-1:0] rd_start, rd_end, rd_pts, rd_cov;

  assign rd_start = row_rd_q[IW-1:0];
  assign rd_end   = row_rd_q[2*IW-1:IW];
  assign rd_pts   = row_rd_q[3*IW-1:2*IW];
  assign rd_cov   = row_rd_q[4*IW-1:3*IW];

  // Calculate: order check, gap and threshold compare
  logic             present, not_above, gap_big;
  logic [IW-1:0]    gap;
  logic [IW+ThrW-1:0] gap_cmp, thr_cmp;
  logic             present_q, oerr_q, big_q;
  logic [IW-1:0]    gap_q;

  assign present   = vld_rd_q && in_range_q;
  assign not_above = pidx_q <= rd_end;
  assign gap       = pidx_q - rd_end;
  assign gap_cmp   = {{ThrW{1'b0}}, gap};
  assign thr_cmp   = {{IW{1'b0}}, thr_q};
  assign gap_big   = gap_cmp > thr_cmp;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_en) begin
      present_q <= present;
      oerr_q    <= present && (op_q == OP_ADD) && not_above;
      gap_q     <= gap;
      big_q     <= gap_big;
    end
  end

  // Saturating counters
  logic [IW:0]     pts_sum, cov_sum;
  logic [IW-1:0]   pts_new, cov_new, cov_inc;
  logic [CountW:0] tot_sum;
  logic [CountW-1:0] tot_q, tot_new, tot_out;
  logic            tot_inc;

  assign pts_sum = {1'b0, rd_pts} + (IW+1)'(1);
  assign pts_new = pts_sum[IW] ? {IW{1'b1}} : pts_sum[IW-1:0];
  assign cov_inc = big_q ? IW'(1) : gap_q;
  assign cov_sum = {1'b0, rd_cov} + {1'b0, cov_inc};
  assign cov_new = cov_sum[IW] ? {IW{1'b1}} : cov_sum[IW-1:0];
  assign tot_sum = {1'b0, tot_q} + (CountW+1)'(1);
  assign tot_new = tot_sum[CountW] ? {CountW{1'b1}} : tot_sum[CountW-1:0];
  assign tot_out = tot_inc ? tot_new : tot_q;

  // Update: choose the new row and the result fields
  logic          r_opened, r_iopened, r_ivalid;
  logic [IW-1:0] r_start, r_end, r_pts, r_cov;

  always_comb begin
    row_we    = 1'b0;
    row_wd    = row_rd_q;
    tot_inc   = 1'b0;
    r_opened  = 1'b0;
    r_iopened = 1'b0;
    r_ivalid  = 1'b0;
    r_start   = '0;
    r_end     = '0;
    r_pts     = '0;
    r_cov     = '0;
    if (in_range_q) begin
      if (op_q == OP_QUERY) begin
        if (present_q) begin
          r_ivalid = 1'b1;
          r_start  = rd_start;
          r_end    = rd_end;
          r_pts    = rd_pts;
          r_cov    = rd_cov;
        end
      end else if (!present_q) begin
        // Open the cell and its first interval
        row_we    = 1'b1;
        row_wd    = {IW'(1), IW'(1), pidx_q, pidx_q};
        tot_inc   = 1'b1;
        r_opened  = 1'b1;
        r_iopened = 1'b1;
        r_pts     = IW'(1);
        r_cov     = IW'(1);
      end else if (oerr_q) begin
        // Drop the point, report current counts
        r_pts = rd_pts;
        r_cov = rd_cov;
      end else begin
        row_we = 1'b1;
        r_pts  = pts_new;
        r_cov  = cov_new;
        if (big_q) begin
          // Close the open interval and start a new one here
          row_wd    = {cov_new, pts_new, pidx_q, pidx_q};
          tot_inc   = 1'b1;
          r_ivalid  = 1'b1;
          r_iopened = 1'b1;
          r_start   = rd_start;
          r_end     = rd_end;
        end else begin
          // Extend the open interval
          row_wd = {cov_new, pts_new, pidx_q, rd_start};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
    end else if (cmd_i.upd_en && tot_inc) begin
      tot_q <= tot_new;
    end
  end

  // Result register
  logic [MDataW-1:0] m_tdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_en) begin
      m_tdata_q <= {{MDataPad{1'b0}}, oerr_q, tot_out,
                    to_port(r_cov), to_port(r_pts), to_port(r_end), to_port(r_start),
                    r_ivalid, r_iopened, r_opened, present_q};
    end
  end

  assign m_tdata_o = m_tdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/per_cell_interval_coalescer_top.sv =====
// Top level: per-cell interval coalescer with stream ports and one threshold register.
`default_nettype none

// Each input beat either adds a point index to a spatial cell or queries a cell, and gives exactly
// one result beat. An add whose gap to the cell's open end exceeds the threshold closes that
// interval, reports it and opens a new one; a gap up to it extends it; an index not above the open
// end sets order_error and changes nothing. Cells at or beyond CELL_COUNT are reported absent.
// After reset the valid store is swept, one cell per cycle, over all CELL_COUNT cells (4096 at
// the default) with s_axis_tready low. After that each beat goes through the cell store's
// registered read, the gap subtract and threshold compare, then the saturating count updates
// with the write back. A new beat is taken while the previous result still waits on the master
// side. Write gap_threshold only while the block is idle.
module per_cell_interval_coalescer_top #(
  parameter int unsigned CELL_COUNT = pcic_pkg::CELL_COUNT_DEF,
  parameter int unsigned INDEX_BITS = pcic_pkg::INDEX_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [pcic_pkg::ThrW-1:0]   cfg_wdata_i,     // gap_threshold
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [pcic_pkg::SDataW-1:0] s_axis_tdata,    // point_index[47:0], cell_number[59:48]
  input  wire logic [pcic_pkg::SUserW-1:0] s_axis_tuser,    // op[0]
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [pcic_pkg::MDataW-1:0]      m_axis_tdata     // cell_present[0], cell_opened[1],
                                                            // interval_opened[2],
                                                            // interval_valid[3],
                                                            // interval_start[51:4],
                                                            // interval_end[99:52],
                                                            // points_in_cell[147:100],
                                                            // covered_in_cell[195:148],
                                                            // interval_count[227:196],
                                                            // order_error[228]
);
  import pcic_pkg::*;

  pcic_cmd_t  cmd;
  pcic_stat_t stat;

  pcic_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  pcic_dp #(
    .CELL_COUNT (CELL_COUNT),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_tdata_o   (m_axis_tdata)
  );

  // Update only into a free result slot
  a_upd_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.upd_en |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before it was taken");

  // Update always presents a result beat next
  a_upd_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.upd_en |=> m_axis_tvalid)
    else $error("update did not present a result beat");

  // One beat in flight: no accept straight after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted while one is in flight");

  // An ignored out-of-order point never reports an interval
  a_oerr_no_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[MBitOerr] && m_axis_tdata[MBitIvalid]))
    else $error("order error together with an interval");

endmodule

`default_nettype wire

// ===== dv/tb_per_cell_interval_coalescer_top.sv =====
`timescale 1ns / 100ps
// Testbench: per-cell interval coalescer, directed and random beats checked against a cell model.
module tb_per_cell_interval_coalescer_top;
  import pcic_pkg::*;

  localparam int unsigned NUM_CELLS    = 4096;
  localparam logic [47:0] INDEX_MAX    = '1;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned RANDOM_BEATS = 200;
  localparam int unsigned REPORT_LIMIT = 10;

  // One result beat, unpacked
  typedef struct {
    bit        present;
    bit        cell_new;
    bit        run_new;
    bit        run_valid;
    bit [47:0] run_first;
    bit [47:0] run_last;
    bit [47:0] points;
    bit [47:0] covered;
    bit [31:0] intervals;
    bit        order_err;
  } cell_report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [ThrW-1:0]      cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [SDataW-1:0]    s_axis_tdata;
  logic [SUserW-1:0]    s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [MDataW-1:0]    m_axis_tdata;

  // Cell model state
  bit        cell_live    [NUM_CELLS];
  bit [47:0] run_start    [NUM_CELLS];
  bit [47:0] run_end      [NUM_CELLS];
  bit [47:0] cell_points  [NUM_CELLS];
  bit [47:0] cell_covered [NUM_CELLS];
  bit [31:0] intervals_total = '0;
  bit [31:0] gap_limit       = '0;

  cell_report_t pending_reports[$];
  int unsigned  fail_count    = 0;
  int unsigned  quiet_cycles  = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;

  per_cell_interval_coalescer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Saturating add at index width
  function automatic bit [47:0] add_sat48(input bit [47:0] a, input bit [63:0] b);
    bit [64:0] sum;
    sum = {17'b0, a} + {1'b0, b};
    return (sum > {17'b0, INDEX_MAX}) ? INDEX_MAX : sum[47:0];
  endfunction

  // Apply one beat to the cell model and return the report it should produce
  function automatic cell_report_t coalesce_point(input logic op, input bit [47:0] idx,
                                                  input bit [11:0] cell_no);
    cell_report_t r;
    bit [63:0]    gap;
    r = '{default: '0};
    r.present = cell_live[cell_no];
    if (op == OP_QUERY) begin
      if (r.present) begin
        r.run_valid = 1'b1;
        r.run_first = run_start[cell_no];
        r.run_last  = run_end[cell_no];
        r.points    = cell_points[cell_no];
        r.covered   = cell_covered[cell_no];
      end
    end else if (!r.present) begin
      // open the cell and its first run
      cell_live[cell_no]    = 1'b1;
      run_start[cell_no]    = idx;
      run_end[cell_no]      = idx;
      cell_points[cell_no]  = 48'd1;
      cell_covered[cell_no] = 48'd1;
      if (intervals_total != '1) intervals_total++;
      r.cell_new = 1'b1;
      r.run_new  = 1'b1;
      r.points   = 48'd1;
      r.covered  = 48'd1;
    end else if (idx <= run_end[cell_no]) begin
      r.order_err = 1'b1;
      r.points    = cell_points[cell_no];
      r.covered   = cell_covered[cell_no];
    end else begin
      gap = {16'b0, idx} - {16'b0, run_end[cell_no]};
      cell_points[cell_no] = add_sat48(cell_points[cell_no], 64'd1);
      if (gap > {32'b0, gap_limit}) begin
        // close the open run and start a new one here
        r.run_valid = 1'b1;
        r.run_new   = 1'b1;
        r.run_first = run_start[cell_no];
        r.run_last  = run_end[cell_no];
        run_start[cell_no]    = idx;
        run_end[cell_no]      = idx;
        cell_covered[cell_no] = add_sat48(cell_covered[cell_no], 64'd1);
        if (intervals_total != '1) intervals_total++;
      end else begin
        run_end[cell_no]      = idx;
        cell_covered[cell_no] = add_sat48(cell_covered[cell_no], gap);
      end
      r.points  = cell_points[cell_no];
      r.covered = cell_covered[cell_no];
    end
    r.intervals = intervals_total;
    return r;
  endfunction

  // Offer one beat, idling at random first, and record its expected report once taken
  task automatic send_beat(input logic op, input bit [47:0] idx, input bit [11:0] cell_no);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {4'b0, cell_no, idx};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_reports.push_back(coalesce_point(op, idx, cell_no));
  endtask

  // Drain the block, then write the threshold
  task automatic set_gap_threshold(input bit [31:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    gap_limit = value;
  endtask

  task automatic note_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Absent cells, opening, order errors, zero threshold and the index extremes
  task automatic test_cell_lifecycle();
    set_gap_threshold(32'd0);
    send_beat(OP_QUERY, 48'h0,            12'h000);
    send_beat(OP_ADD,   48'd10,           12'h000);
    send_beat(OP_QUERY, INDEX_MAX,        12'h000);
    send_beat(OP_ADD,   48'd10,           12'h000);
    send_beat(OP_ADD,   48'd5,            12'h000);
    send_beat(OP_ADD,   48'd11,           12'h000);
    send_beat(OP_ADD,   INDEX_MAX,        12'hFFF);
    send_beat(OP_ADD,   48'h0,            12'hFFF);
    send_beat(OP_QUERY, 48'h0,            12'hFFF);
    send_beat(OP_ADD,   48'h0,            12'hAAA);
    send_beat(OP_ADD,   48'h5555_5555_5555, 12'h555);
    send_beat(OP_ADD,   48'hAAAA_AAAA_AAAA, 12'hAAA);
    send_beat(OP_QUERY, 48'h0,            12'h555);
    send_beat(OP_QUERY, 48'h0,            12'hAAA);
  endtask

  // Largest threshold: a gap at the threshold extends, one of 2^32 must close untruncated
  task automatic test_full_width_gap();
    set_gap_threshold(32'hFFFF_FFFF);
    send_beat(OP_ADD,   48'h100,          12'h007);
    send_beat(OP_ADD,   48'h1_0000_00FF,  12'h007);
    send_beat(OP_ADD,   48'h2_0000_00FF,  12'h007);
    send_beat(OP_ADD,   48'h3_0000_00FF,  12'h007);
    send_beat(OP_QUERY, 48'h0,            12'h007);
    send_beat(OP_ADD,   48'h103_0000_00FF, 12'h007);
    send_beat(OP_QUERY, 48'h0,            12'h007);
  endtask

  // Mostly ordered adds to a few busy cells, with queries, stray cells and order errors mixed in
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input bit [31:0] threshold);
    bit [11:0] hot_cells [6];
    bit [11:0] cell_no;
    bit [47:0] idx;
    bit [63:0] step;
    bit [63:0] sum;
    int unsigned pick;
    int unsigned back;
    set_gap_threshold(threshold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    foreach (hot_cells[i]) hot_cells[i] = 12'($urandom);
    repeat (RANDOM_BEATS) begin
      pick    = $urandom_range(99);
      cell_no = hot_cells[$urandom_range(5)];
      idx     = {16'($urandom), $urandom};
      if (pick < 8) begin
        if ($urandom_range(1)) cell_no = 12'($urandom);
        send_beat(OP_QUERY, idx, cell_no);
      end else if (pick < 14) begin
        send_beat(OP_ADD, idx, 12'($urandom));
      end else if (pick < 22) begin
        // repeat or step back from the open end
        if (cell_live[cell_no]) begin
          back = $urandom_range(0, 3);
          idx  = (run_end[cell_no] >= back) ? run_end[cell_no] - back : run_end[cell_no];
        end
        send_beat(OP_ADD, idx, cell_no);
      end else begin
        if (!cell_live[cell_no]) begin
          idx = {16'($urandom_range(0, 16'h7FFF)), $urandom};
        end else begin
          pick = $urandom_range(99);
          if (pick < 45) begin
            if (gap_limit == 0)
              step = 64'd1;
            else if ($urandom_range(1))
              step = 64'($urandom_range(1, (gap_limit < 16) ? gap_limit : 16));
            else
              step = 64'($urandom_range(1, gap_limit));
          end else if (pick < 85) begin
            step = {32'b0, gap_limit} + 64'($urandom_range(1, 16));
          end else begin
            step = {24'b0, 8'($urandom), $urandom} + 64'd1;
          end
          sum = {16'b0, run_end[cell_no]} + step;
          idx = (sum > {16'b0, INDEX_MAX}) ? INDEX_MAX : sum[47:0];
        end
        send_beat(OP_ADD, idx, cell_no);
      end
    end
  endtask

  // Drive the receiver's back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin : check_reports
    cell_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result beat: %h", m_axis_tdata);
      end else begin
        want = pending_reports.pop_front();
        note_field("cell_present",    64'(want.present),   64'(m_axis_tdata[0]));
        note_field("cell_opened",     64'(want.cell_new),  64'(m_axis_tdata[1]));
        note_field("interval_opened", 64'(want.run_new),   64'(m_axis_tdata[2]));
        note_field("interval_valid",  64'(want.run_valid), 64'(m_axis_tdata[3]));
        note_field("interval_start",  64'(want.run_first), 64'(m_axis_tdata[51:4]));
        note_field("interval_end",    64'(want.run_last),  64'(m_axis_tdata[99:52]));
        note_field("points_in_cell",  64'(want.points),    64'(m_axis_tdata[147:100]));
        note_field("covered_in_cell", 64'(want.covered),   64'(m_axis_tdata[195:148]));
        note_field("interval_count",  64'(want.intervals), 64'(m_axis_tdata[227:196]));
        note_field("order_error",     64'(want.order_err), 64'(m_axis_tdata[228]));
      end
    end
  end

  // Stop the run if no beat moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_cell_lifecycle();
    test_full_width_gap();
    test_random_traffic(30, 75, $urandom_range(4, 64));
    test_random_traffic(75, 30, 32'd0);
    test_random_traffic(0, 0, 32'hFFFF_FFFF);

    // hold off until every report is back, then let the pipeline settle
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pcic_pkg.sv
hw/rtl/pcic_ctrl.sv
hw/rtl/pcic_dp.sv
hw/rtl/per_cell_interval_coalescer_top.sv
dv/tb_per_cell_interval_coalescer_top.sv
